[hw/rtl/xbr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM block receiver package
// Shared payload types, command codes and protocol constants.
// ----------------------------------------------------------------------------
package xbr_pkg;

  localparam logic [7:0] SYM_SOH    = 8'h01;
  localparam logic [7:0] SYM_EOT    = 8'h04;
  localparam logic [7:0] SYM_SUB    = 8'h1A;
  localparam logic [7:0] MAX_BLOCKS = 8'd128;
  localparam logic [7:0] PAD_NONE   = 8'd128;
  localparam logic [7:0] RETRY_MAX  = 8'd255;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_STORE = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_NAK   = 2'd2,
    KIND_EOT   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    RSN_START = 3'd0,
    RSN_BNUM  = 3'd1,
    RSN_BCMP  = 3'd2,
    RSN_CSUM  = 3'd3,
    RSN_CAP   = 3'd4
  } reason_e;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STORE = 3'd1,
    CMD_ACK   = 3'd2,
    CMD_NAK   = 3'd3,
    CMD_EOT   = 3'd4
  } cmd_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [13:0] write_address;
    logic [7:0]  write_byte;
    logic [2:0]  error_reason;
    logic [7:0]  error_detail;
    logic [7:0]  block_count;
    logic [14:0] byte_count;
    logic [7:0]  retry_count;
  } out_t;

  typedef struct packed {
    cmd_e       op;
    reason_e    reason;
    logic [7:0] data;
    logic [6:0] index;
    logic [7:0] blocks;
  } cmd_t;

endpackage

[hw/rtl/xbr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM block receiver front end
// Frame parser that checks each byte and pushes a command where a reply is due.
// ----------------------------------------------------------------------------
module xbr_front import xbr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  input  logic q_ready_i,
  output logic push_o,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEAD,
    PH_BNUM,
    PH_BCMP,
    PH_DATA,
    PH_CSUM,
    PH_DONE
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] blocks_q, blocks_d;
  logic [6:0] idx_q, idx_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] expect_num;
  logic [7:0] b;
  logic       fire;

  assign in_ready_o = q_ready_i;
  assign fire       = in_valid_i && q_ready_i;
  assign b          = in_data_i.rx_byte;
  assign expect_num = blocks_q + 8'd1;

  always_comb begin
    phase_d    = phase_q;
    blocks_d   = blocks_q;
    idx_d      = idx_q;
    sum_d      = sum_q;
    push_o     = 1'b0;
    cmd_o.op     = CMD_NAK;
    cmd_o.reason = RSN_START;
    cmd_o.data   = b;
    cmd_o.index  = idx_q;
    cmd_o.blocks = blocks_q;
    if (fire) begin
      if (in_data_i.operation) begin
        phase_d      = PH_HEAD;
        blocks_d     = 8'd0;
        idx_d        = 7'd0;
        sum_d        = 8'd0;
        push_o       = 1'b1;
        cmd_o.op     = CMD_START;
        cmd_o.blocks = 8'd0;
      end else begin
        unique case (phase_q)
          PH_HEAD: begin
            if (b == SYM_EOT) begin
              push_o   = 1'b1;
              cmd_o.op = CMD_EOT;
              phase_d  = PH_DONE;
            end else if (b != SYM_SOH) begin
              push_o = 1'b1;
            end else if (blocks_q >= MAX_BLOCKS) begin
              push_o       = 1'b1;
              cmd_o.reason = RSN_CAP;
            end else begin
              phase_d = PH_BNUM;
            end
          end
          PH_BNUM: begin
            if (b != expect_num) begin
              push_o       = 1'b1;
              cmd_o.reason = RSN_BNUM;
              phase_d      = PH_HEAD;
            end else begin
              phase_d = PH_BCMP;
            end
          end
          PH_BCMP: begin
            if (b != ~expect_num) begin
              push_o       = 1'b1;
              cmd_o.reason = RSN_BCMP;
              phase_d      = PH_HEAD;
            end else begin
              phase_d = PH_DATA;
              idx_d   = 7'd0;
              sum_d   = 8'd0;
            end
          end
          PH_DATA: begin
            push_o   = 1'b1;
            cmd_o.op = CMD_STORE;
            sum_d    = sum_q + b;
            idx_d    = idx_q + 7'd1;
            if (idx_q == 7'd127) begin
              phase_d = PH_CSUM;
            end
          end
          PH_CSUM: begin
            push_o  = 1'b1;
            phase_d = PH_HEAD;
            if (b != sum_q) begin
              cmd_o.reason = RSN_CSUM;
              cmd_o.data   = b ^ sum_q;
            end else begin
              blocks_d     = expect_num;
              cmd_o.op     = CMD_ACK;
              cmd_o.blocks = expect_num;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      blocks_q <= 8'd0;
      idx_q    <= 7'd0;
      sum_q    <= 8'd0;
    end else begin
      phase_q  <= phase_d;
      blocks_q <= blocks_d;
      idx_q    <= idx_d;
      sum_q    <= sum_d;
    end
  end

endmodule

[hw/rtl/xbr_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM block receiver command queue
// Short FIFO that decouples the frame parser from the result builder.
// ----------------------------------------------------------------------------
module xbr_queue import xbr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, rd_q;
  logic [Q_CNT_W-1:0] cnt_q;
  logic               do_push, do_pop;

  assign ready_o = (cnt_q != Q_CNT_W'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/xbr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM block receiver back end
// Builds result items from commands and keeps retry and padding counters.
// ----------------------------------------------------------------------------
module xbr_back import xbr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  cmd_t cmd_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic        out_valid_q;
  out_t        out_q, out_d;
  logic [7:0]  nak_q, nak_d;
  logic [7:0]  pad_q, pad_d;
  logic [7:0]  last_pad_q, last_pad_d;
  logic [7:0]  pad_cur;
  logic [7:0]  nak_inc;
  logic [7:0]  blocks_m1;
  logic [14:0] byte_cnt;

  assign pop_o       = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign pad_cur   = (cmd_i.index == 7'd0) ? PAD_NONE : pad_q;
  assign nak_inc   = (nak_q != RETRY_MAX) ? nak_q + 8'd1 : nak_q;
  assign blocks_m1 = cmd_i.blocks - 8'd1;
  assign byte_cnt  = (cmd_i.blocks == 8'd0) ? 15'd0 :
                     {blocks_m1, 7'd0} + {7'd0, last_pad_q};

  always_comb begin
    out_d      = '0;
    nak_d      = nak_q;
    pad_d      = pad_q;
    last_pad_d = last_pad_q;
    unique case (cmd_i.op)
      CMD_START: begin
        out_d.kind = KIND_NAK;
        nak_d      = 8'd0;
        pad_d      = PAD_NONE;
        last_pad_d = PAD_NONE;
      end
      CMD_STORE: begin
        out_d.kind          = KIND_STORE;
        out_d.write_address = {cmd_i.blocks[6:0], cmd_i.index};
        out_d.write_byte    = cmd_i.data;
        if (cmd_i.data == SYM_SUB) begin
          pad_d = (pad_cur == PAD_NONE) ? {1'b0, cmd_i.index} : pad_cur;
        end else begin
          pad_d = PAD_NONE;
        end
      end
      CMD_ACK: begin
        out_d.kind        = KIND_ACK;
        out_d.block_count = cmd_i.blocks;
        out_d.retry_count = nak_q;
        last_pad_d        = pad_q;
      end
      CMD_NAK: begin
        out_d.kind         = KIND_NAK;
        out_d.error_reason = cmd_i.reason;
        out_d.error_detail = cmd_i.data;
        out_d.block_count  = cmd_i.blocks;
        out_d.retry_count  = nak_inc;
        nak_d              = nak_inc;
      end
      CMD_EOT: begin
        out_d.kind        = KIND_EOT;
        out_d.block_count = cmd_i.blocks;
        out_d.byte_count  = byte_cnt;
        out_d.retry_count = nak_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      nak_q       <= 8'd0;
      pad_q       <= PAD_NONE;
      last_pad_q  <= PAD_NONE;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        nak_q       <= nak_d;
        pad_q       <= pad_d;
        last_pad_q  <= last_pad_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/xmodem_block_receiver_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM block receiver unit
// Checksum XMODEM receiver that takes one serial byte per transfer.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   in_data_i  (in_t)
// out       output     out_valid_o / out_ready_i out_data_o (out_t)
//
// One input transfer can be taken every cycle while the command queue has room;
// a result passes the queue and the output register before it is presented.
// The frame parser, a two-entry command queue and the output register set
// the throughput; each stage stalls only on the one after it.
// Reset clears the session to idle; bytes before the first start are dropped.
// ----------------------------------------------------------------------------
module xmodem_block_receiver_unit import xbr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic fr_push;
  cmd_t fr_cmd;
  logic q_ready;
  logic q_valid;
  cmd_t q_cmd;
  logic bk_pop;

  xbr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_ready_i  (q_ready),
    .push_o     (fr_push),
    .cmd_o      (fr_cmd)
  );

  xbr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .cmd_i   (fr_cmd),
    .ready_o (q_ready),
    .pop_i   (bk_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  xbr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .cmd_i       (q_cmd),
    .pop_o       (bk_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_push |-> q_ready)
    else $error("command pushed into a full queue");

  a_store_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KIND_STORE) |->
      (out_data_o.retry_count == 8'd0 && out_data_o.block_count == 8'd0 &&
       out_data_o.byte_count == 15'd0))
    else $error("payload store carries status fields");

  a_nak_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bk_pop && q_cmd.op == CMD_NAK) |=> (out_data_o.retry_count != 8'd0))
    else $error("error NAK without a retry count");

endmodule

[tb/tb_xmodem_block_receiver_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM block receiver unit testbench
// Drives serial bytes and session starts through the input channel and checks
// every reply against an in-bench model of the checksum receiver or a fixed
// expected reply. A directed table of frames comes first, then randomized
// sessions of good, corrupted and truncated frames.
// ----------------------------------------------------------------------------
module tb_xmodem_block_receiver_unit;
  import xbr_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 800000;
  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned BURST_ITEMS  = 400;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef enum logic [2:0] {
    PS_IDLE, PS_HEAD, PS_BNUM, PS_BCMP, PS_DATA, PS_CSUM, PS_DONE
  } parse_e;

  typedef enum int {ROW_PRED, ROW_NONE, ROW_FIXED} row_e;

  typedef enum int {FLAW_NONE, FLAW_BNUM, FLAW_BCMP, FLAW_CSUM, FLAW_CUT} flaw_e;

  typedef struct {
    in_t         item;
    int unsigned rep;
    row_e        mode;
    out_t        res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  parse_e     rx_phase      = PS_IDLE;
  logic [7:0] blk_ok        = '0;
  logic [6:0] pay_idx       = '0;
  logic [7:0] pay_sum       = '0;
  logic [7:0] pad_from      = PAD_NONE;
  logic [7:0] nak_cnt       = '0;
  logic [7:0] last_pad_from = PAD_NONE;

  out_t        pending_replies[$];
  dir_row_t    dir_tab[$];
  int unsigned n_items   = 0;
  int unsigned n_replies = 0;
  int unsigned n_errors  = 0;
  int unsigned n_cycles  = 0;
  int unsigned hold_left = 0;
  bit          no_idle   = 1'b0;

  xmodem_block_receiver_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic out_t mk_reply(kind_e k, reason_e rs, logic [7:0] det,
                                    logic [7:0] blk, logic [14:0] cnt, logic [7:0] rty);
    out_t r;
    r = '0;
    r.kind = k;
    if (k == KIND_NAK) begin
      r.error_reason = rs;
      r.error_detail = det;
    end
    r.block_count = blk;
    r.byte_count  = cnt;
    r.retry_count = rty;
    return r;
  endfunction

  function automatic out_t nak_reply(reason_e rs, logic [7:0] det);
    if (nak_cnt != RETRY_MAX) begin
      nak_cnt = nak_cnt + 8'd1;
    end
    rx_phase = PS_HEAD;
    return mk_reply(KIND_NAK, rs, det, blk_ok, '0, nak_cnt);
  endfunction

  function automatic bit predict_reply(input in_t it, output out_t r);
    logic [7:0]  b;
    logic [7:0]  want;
    logic [15:0] cnt;
    b    = it.rx_byte;
    want = blk_ok + 8'd1;
    r    = '0;
    if (it.operation) begin
      rx_phase      = PS_HEAD;
      blk_ok        = '0;
      pay_idx       = '0;
      pay_sum       = '0;
      pad_from      = PAD_NONE;
      nak_cnt       = '0;
      last_pad_from = PAD_NONE;
      r.kind        = KIND_NAK;
      return 1'b1;
    end
    case (rx_phase)
      PS_HEAD: begin
        if (b == SYM_EOT) begin
          cnt = '0;
          if (blk_ok != 0) begin
            cnt = 16'd128 * (16'(blk_ok) - 16'd1) + 16'(last_pad_from);
          end
          r = mk_reply(KIND_EOT, RSN_START, '0, blk_ok, cnt[14:0], nak_cnt);
          rx_phase = PS_DONE;
          return 1'b1;
        end
        if (b != SYM_SOH) begin
          r = nak_reply(RSN_START, b);
          return 1'b1;
        end
        if (blk_ok >= MAX_BLOCKS) begin
          r = nak_reply(RSN_CAP, b);
          return 1'b1;
        end
        rx_phase = PS_BNUM;
        return 1'b0;
      end
      PS_BNUM: begin
        if (b != want) begin
          r = nak_reply(RSN_BNUM, b);
          return 1'b1;
        end
        rx_phase = PS_BCMP;
        return 1'b0;
      end
      PS_BCMP: begin
        if (b != ~want) begin
          r = nak_reply(RSN_BCMP, b);
          return 1'b1;
        end
        rx_phase = PS_DATA;
        pay_idx  = '0;
        pay_sum  = '0;
        pad_from = PAD_NONE;
        return 1'b0;
      end
      PS_DATA: begin
        pay_sum = pay_sum + b;
        if (b == SYM_SUB) begin
          if (pad_from == PAD_NONE) begin
            pad_from = {1'b0, pay_idx};
          end
        end else begin
          pad_from = PAD_NONE;
        end
        r.kind          = KIND_STORE;
        r.write_address = {blk_ok[6:0], pay_idx};
        r.write_byte    = b;
        if (pay_idx == 7'd127) begin
          rx_phase = PS_CSUM;
        end
        pay_idx = pay_idx + 7'd1;
        return 1'b1;
      end
      PS_CSUM: begin
        if (b != pay_sum) begin
          r = nak_reply(RSN_CSUM, b ^ pay_sum);
          return 1'b1;
        end
        blk_ok        = blk_ok + 8'd1;
        last_pad_from = pad_from;
        r = mk_reply(KIND_ACK, RSN_START, '0, blk_ok, '0, nak_cnt);
        rx_phase = PS_HEAD;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_item(input in_t it, input row_e mode = ROW_PRED, input out_t fixed = '0);
    out_t r;
    bit   has;
    while (!no_idle && $urandom_range(0, 99) < 26) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    n_items++;
    has = predict_reply(it, r);
    if (mode == ROW_FIXED) begin
      pending_replies.push_back(fixed);
    end else if (mode == ROW_PRED && has) begin
      pending_replies.push_back(r);
    end
  endtask

  task automatic send_rx(input logic [7:0] b);
    send_item('{operation: 1'b0, rx_byte: b});
  endtask

  task automatic send_start();
    send_item('{operation: 1'b1, rx_byte: 8'($urandom_range(0, 255))});
  endtask

  task automatic send_block(input flaw_e flaw);
    logic [7:0] num;
    logic [7:0] sum;
    logic [7:0] b;
    int         pad_len;
    int         cut_at;
    num     = blk_ok + 8'd1;
    sum     = '0;
    pad_len = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 128) : 0;
    cut_at  = (flaw == FLAW_CUT) ? $urandom_range(0, 127) : 128;
    send_rx(SYM_SOH);
    if (flaw == FLAW_BNUM) begin
      send_rx(num ^ 8'($urandom_range(1, 255)));
      return;
    end
    send_rx(num);
    if (flaw == FLAW_BCMP) begin
      send_rx(~num ^ 8'($urandom_range(1, 255)));
      return;
    end
    send_rx(~num);
    for (int i = 0; i < cut_at; i++) begin
      if (i >= 128 - pad_len || $urandom_range(0, 7) == 0) begin
        b = SYM_SUB;
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      sum = sum + b;
      send_rx(b);
    end
    if (flaw == FLAW_CUT) begin
      return;
    end
    if (flaw == FLAW_CSUM) begin
      sum = sum ^ 8'($urandom_range(1, 255));
    end
    send_rx(sum);
  endtask

  task automatic run_session();
    int pick;
    send_start();
    repeat ($urandom_range(1, 5)) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_block(FLAW_NONE);
      end else if (pick < 68) begin
        send_block(FLAW_BNUM);
      end else if (pick < 76) begin
        send_block(FLAW_BCMP);
      end else if (pick < 86) begin
        send_block(FLAW_CSUM);
      end else if (pick < 94) begin
        send_block(FLAW_CUT);
      end else begin
        repeat ($urandom_range(1, 4)) send_rx(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 9) < 7) begin
      send_rx(SYM_EOT);
      repeat ($urandom_range(0, 2)) send_rx(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic add_row(input logic op, input logic [7:0] b, input int unsigned rep,
                         input row_e mode, input out_t res = '0);
    dir_tab.push_back('{item: '{operation: op, rx_byte: b}, rep: rep, mode: mode, res: res});
  endtask

  task automatic check_field(input string name, input logic [15:0] e, input logic [15:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
      n_errors++;
    end
  endtask

  task automatic check_reply(input out_t got);
    out_t e;
    if (pending_replies.size() == 0) begin
      $display("%0t: unexpected reply, expected none, actual %0h", $time, got);
      n_errors++;
      return;
    end
    e = pending_replies.pop_front();
    check_field("kind", 16'(e.kind), 16'(got.kind));
    check_field("write_address", 16'(e.write_address), 16'(got.write_address));
    check_field("write_byte", 16'(e.write_byte), 16'(got.write_byte));
    check_field("error_reason", 16'(e.error_reason), 16'(got.error_reason));
    check_field("error_detail", 16'(e.error_detail), 16'(got.error_detail));
    check_field("block_count", 16'(e.block_count), 16'(got.block_count));
    check_field("byte_count", 16'(e.byte_count), 16'(got.byte_count));
    check_field("retry_count", 16'(e.retry_count), 16'(got.retry_count));
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        check_reply(out_data_o);
        n_replies++;
        if (n_replies == 300 || n_replies == 800) begin
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(0, 99) >= 26);
      end
    end
  end

  initial begin
    while (n_cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      n_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned base;
    add_row(1'b0, 8'h00, 1, ROW_NONE);
    add_row(1'b0, SYM_SOH, 1, ROW_NONE);
    add_row(1'b1, 8'hFF, 1, ROW_FIXED,
            mk_reply(KIND_NAK, RSN_START, 8'h00, 8'd0, 15'd0, 8'd0));
    add_row(1'b0, 8'hFF, 1, ROW_FIXED,
            mk_reply(KIND_NAK, RSN_START, 8'hFF, 8'd0, 15'd0, 8'd1));
    add_row(1'b0, 8'h00, 1, ROW_FIXED,
            mk_reply(KIND_NAK, RSN_START, 8'h00, 8'd0, 15'd0, 8'd2));
    add_row(1'b0, SYM_SOH, 1, ROW_NONE);
    add_row(1'b0, 8'h02, 1, ROW_FIXED,
            mk_reply(KIND_NAK, RSN_BNUM, 8'h02, 8'd0, 15'd0, 8'd3));
    add_row(1'b0, SYM_SOH, 1, ROW_NONE);
    add_row(1'b0, 8'h01, 1, ROW_NONE);
    add_row(1'b0, 8'h00, 1, ROW_FIXED,
            mk_reply(KIND_NAK, RSN_BCMP, 8'h00, 8'd0, 15'd0, 8'd4));
    add_row(1'b0, SYM_SOH, 1, ROW_NONE);
    add_row(1'b0, 8'h01, 1, ROW_NONE);
    add_row(1'b0, 8'hFE, 1, ROW_NONE);
    add_row(1'b0, 8'hFF, 128, ROW_PRED);
    add_row(1'b0, 8'h81, 1, ROW_FIXED,
            mk_reply(KIND_NAK, RSN_CSUM, 8'h01, 8'd0, 15'd0, 8'd5));
    add_row(1'b0, SYM_SOH, 1, ROW_NONE);
    add_row(1'b0, 8'h01, 1, ROW_NONE);
    add_row(1'b0, 8'hFE, 1, ROW_NONE);
    add_row(1'b0, 8'h55, 100, ROW_PRED);
    add_row(1'b0, SYM_SUB, 28, ROW_PRED);
    add_row(1'b0, 8'h0C, 1, ROW_FIXED,
            mk_reply(KIND_ACK, RSN_START, 8'h00, 8'd1, 15'd0, 8'd5));
    add_row(1'b0, SYM_EOT, 1, ROW_FIXED,
            mk_reply(KIND_EOT, RSN_START, 8'h00, 8'd1, 15'd100, 8'd5));
    add_row(1'b0, SYM_SOH, 1, ROW_NONE);
    add_row(1'b1, 8'h00, 1, ROW_FIXED,
            mk_reply(KIND_NAK, RSN_START, 8'h00, 8'd0, 15'd0, 8'd0));
    add_row(1'b0, SYM_SOH, 1, ROW_NONE);
    add_row(1'b0, 8'h01, 1, ROW_NONE);
    add_row(1'b1, 8'h00, 1, ROW_FIXED,
            mk_reply(KIND_NAK, RSN_START, 8'h00, 8'd0, 15'd0, 8'd0));
    add_row(1'b0, SYM_EOT, 1, ROW_FIXED,
            mk_reply(KIND_EOT, RSN_START, 8'h00, 8'd0, 15'd0, 8'd0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      repeat (dir_tab[i].rep) send_item(dir_tab[i].item, dir_tab[i].mode, dir_tab[i].res);
    end

    base = n_items;
    while (n_items - base < RANDOM_ITEMS) begin
      no_idle = (n_items - base < BURST_ITEMS);
      run_session();
    end
    no_idle = 1'b0;

    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/xbr_pkg.sv
hw/rtl/xbr_front.sv
hw/rtl/xbr_queue.sv
hw/rtl/xbr_back.sv
hw/rtl/xmodem_block_receiver_unit.sv
tb/tb_xmodem_block_receiver_unit.sv
